>>> design/date_validate_and_add_days_defines.svh
// Assertion macros for the date validate and add days block.
// No dependencies; included by the top level after its logic.
`ifndef DATE_VALIDATE_AND_ADD_DAYS_DEFINES_SVH
`define DATE_VALIDATE_AND_ADD_DAYS_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while reset is low
`define DVAD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is low
`define DVAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> design/dvad_pkg.sv
// Constants, status codes and calendar helpers for the date add block.
// No dependencies; imported by date_validate_and_add_days.
`default_nettype none

package dvad_pkg;

    // Field widths
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int DAYS_W   = 16;
    localparam int STATUS_W = 2;

    // Usable bits of the day count and the running day total
    localparam int ADD_WIDTH = 16;
    localparam int TOT_W     = ((ADD_WIDTH > DAY_W) ? ADD_WIDTH : DAY_W) + 1;

    // Calendar limits
    localparam int MIN_YEAR  = 1600;
    localparam int MAX_YEAR  = 9999;
    localparam int MONTHS    = 12;
    localparam int CYCLE_LEN = 400;
    localparam int CENTURY   = 100;
    localparam int R400_W    = 9;

    // year / 400 as (year * DIV400_MUL) >> DIV400_SHIFT, exact for 14-bit years
    localparam int DIV400_SHIFT = 22;
    localparam int DIV400_MUL   = ((1 << DIV400_SHIFT) + CYCLE_LEN - 1) / CYCLE_LEN;
    localparam int DIV400_MUL_W = 14;
    localparam int PROD_W       = YEAR_W + DIV400_MUL_W;
    localparam int DIV400_Q_W   = 6;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_DATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    // Leap year from the two low year bits and the year modulo 400
    function automatic logic is_leap(input logic [1:0] y_low, input logic [R400_W-1:0] r400);
        logic century;
        century = (r400 == R400_W'(CENTURY)) || (r400 == R400_W'(2 * CENTURY))
               || (r400 == R400_W'(3 * CENTURY));
        return (y_low == 2'b00) && !century;
    endfunction

    // Length of a month in days
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
            4'd2:                    len = leap ? DAY_W'(29) : DAY_W'(28);
            default:                 len = DAY_W'(31);
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

>>> design/date_validate_and_add_days.sv
// Steps: divide the year by 400, form the remainder, check the date, then walk month by
// month in S_RUN until the day total fits; an invalid date or a year past the maximum
// goes straight to the output. A new item is taken only after the last one has left S_OUT.
// Input is taken only when the sequencer is idle.
// Reset (synchronous, active low) returns to idle and empties the output register.
// Depends on dvad_pkg and date_validate_and_add_days_defines.svh.
`default_nettype none

module date_validate_and_add_days
    import dvad_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [DAY_W-1:0]     i_day_in,
    input  wire logic [MONTH_W-1:0]   i_month_in,
    input  wire logic [YEAR_W-1:0]    i_year_in,
    input  wire logic [DAYS_W-1:0]    i_days_to_add,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [STATUS_W-1:0]       o_status,
    output logic [DAY_W-1:0]          o_day_out,
    output logic [MONTH_W-1:0]        o_month_out,
    output logic [YEAR_W-1:0]         o_year_out
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_REM   = 6'b000100,
        S_CHECK = 6'b001000,
        S_RUN   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state                  r_state, n_state;
    logic [TOT_W-1:0]        r_total, n_total;
    logic [MONTH_W-1:0]      r_m, n_m;
    logic [YEAR_W-1:0]       r_y, n_y;
    logic [ADD_WIDTH-1:0]    r_add;
    logic [DIV400_Q_W-1:0]   r_q, n_q;
    logic [R400_W-1:0]       r_r400, n_r400;
    logic [STATUS_W-1:0]     r_status, n_status;

    logic                    r_o_valid;
    logic [STATUS_W-1:0]     r_o_status;
    logic [DAY_W-1:0]        r_o_day;
    logic [MONTH_W-1:0]      r_o_month;
    logic [YEAR_W-1:0]       r_o_year;

    logic                    w_in_xfer;
    logic                    w_out_load;
    logic [PROD_W-1:0]       w_prod;
    logic [YEAR_W-1:0]       w_q400;
    logic                    w_leap;
    logic [DAY_W-1:0]        w_len;
    logic [YEAR_W:0]         w_y_inc;
    logic                    w_bad;

    assign w_in_xfer  = i_valid && (r_state == S_IDLE);
    assign w_out_load = (r_state == S_OUT) && (!r_o_valid || !i_stall);

    // Shared datapath: reciprocal multiply, remainder, month length, year step
    assign w_prod  = PROD_W'(r_y) * PROD_W'(DIV400_MUL);
    assign w_q400  = (YEAR_W'(r_q) << 8) + (YEAR_W'(r_q) << 7) + (YEAR_W'(r_q) << 4);
    assign w_leap  = is_leap(r_y[1:0], r_r400);
    assign w_len   = month_len(r_m, w_leap);
    assign w_y_inc = {1'b0, r_y} + (YEAR_W + 1)'(1);
    assign w_bad   = (r_y < YEAR_W'(MIN_YEAR)) || (r_m < MONTH_W'(1))
                  || (r_m > MONTH_W'(MONTHS)) || (r_total[DAY_W-1:0] == '0)
                  || (r_total[DAY_W-1:0] > w_len);

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_total  = r_total;
        n_m      = r_m;
        n_y      = r_y;
        n_q      = r_q;
        n_r400   = r_r400;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // quotient of year by 400
                n_q     = w_prod[DIV400_SHIFT +: DIV400_Q_W];
                n_state = S_REM;
            end
            S_REM: begin
                n_r400  = R400_W'(r_y - w_q400);
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_bad) begin
                    n_status = ST_BAD_DATE;
                    n_state  = S_OUT;
                end else if (r_y > YEAR_W'(MAX_YEAR)) begin
                    n_status = ST_OVERFLOW;
                    n_state  = S_OUT;
                end else begin
                    n_status = ST_OK;
                    n_total  = TOT_W'(r_total[DAY_W-1:0]) + TOT_W'(r_add);
                    n_state  = S_RUN;
                end
            end
            S_RUN: begin
                // subtract one month per cycle, wrap into the next year
                if (r_total > TOT_W'(w_len)) begin
                    n_total = r_total - TOT_W'(w_len);
                    if (r_m == MONTH_W'(MONTHS)) begin
                        n_m = MONTH_W'(1);
                        if (w_y_inc > (YEAR_W + 1)'(MAX_YEAR)) begin
                            n_status = ST_OVERFLOW;
                            n_state  = S_OUT;
                        end else begin
                            n_y    = w_y_inc[YEAR_W-1:0];
                            n_r400 = (r_r400 == R400_W'(CYCLE_LEN - 1)) ? '0
                                   : r_r400 + R400_W'(1);
                        end
                    end else begin
                        n_m = r_m + MONTH_W'(1);
                    end
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_o_valid || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Working registers: capture the item on transfer, then advance
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_total <= TOT_W'(i_day_in);
            r_m     <= i_month_in;
            r_y     <= i_year_in;
            r_add   <= i_days_to_add[ADD_WIDTH-1:0];
        end else begin
            r_total <= n_total;
            r_m     <= n_m;
            r_y     <= n_y;
        end
        r_q      <= n_q;
        r_r400   <= n_r400;
        r_status <= n_status;
    end

    // Output register: saturate on overflow, else the working date
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_status <= r_status;
            if (r_status == ST_OVERFLOW) begin
                r_o_day   <= DAY_W'(31);
                r_o_month <= MONTH_W'(MONTHS);
                r_o_year  <= YEAR_W'(MAX_YEAR);
            end else begin
                r_o_day   <= r_total[DAY_W-1:0];
                r_o_month <= r_m;
                r_o_year  <= r_y;
            end
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_o_valid;
    assign o_status    = r_o_status;
    assign o_day_out   = r_o_day;
    assign o_month_out = r_o_month;
    assign o_year_out  = r_o_year;

`include "date_validate_and_add_days_defines.svh"

    `DVAD_ASSERT_NEXT(a_xfer_starts_div, w_in_xfer, r_state == S_DIV, "transfer did not start division")
    `DVAD_ASSERT_IMPL(a_r400_range, r_state == S_RUN, r_r400 < R400_W'(CYCLE_LEN), "year mod 400 out of range")
    `DVAD_ASSERT_IMPL(a_ok_month, o_valid && (o_status == ST_OK), (o_month_out >= MONTH_W'(1)) && (o_month_out <= MONTH_W'(MONTHS)), "ok result with bad month")
    `DVAD_ASSERT_IMPL(a_ovf_sat, o_valid && (o_status == ST_OVERFLOW), o_year_out == YEAR_W'(MAX_YEAR), "overflow result not saturated")

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for date_validate_and_add_days: directed and random dates,
// predicted results compared field by field. Depends on dvad_pkg and the block RTL.

module testbench;
    import dvad_pkg::*;

    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 250;
    localparam int CALM_ITEMS   = 30;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_LEN     = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 2_500_000;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [DAYS_W-1:0]  days;
    } t_date_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
    } t_date_result;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_valid       = 1'b0;
    logic                o_stall;
    logic [DAY_W-1:0]    i_day_in      = '0;
    logic [MONTH_W-1:0]  i_month_in    = '0;
    logic [YEAR_W-1:0]   i_year_in     = '0;
    logic [DAYS_W-1:0]   i_days_to_add = '0;
    logic                o_valid;
    logic                i_stall       = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [DAY_W-1:0]    o_day_out;
    logic [MONTH_W-1:0]  o_month_out;
    logic [YEAR_W-1:0]   o_year_out;

    t_date_item   date_items[$];
    t_date_result expected_dates[$];
    t_date_item   tx_item;
    int           item_total = 0;
    int           sent_cnt   = 0;
    int           err_cnt    = 0;
    int           cycle_cnt  = 0;
    int           tx_gap     = 0;
    int           rx_gap     = 0;
    int           hold_cnt   = 0;
    bit           hold_done  = 1'b0;
    logic         calm;

    // Turn off idling for the last stretch of items
    assign calm = (sent_cnt + CALM_ITEMS >= item_total);

    date_validate_and_add_days u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_day_in      (i_day_in),
        .i_month_in    (i_month_in),
        .i_year_in     (i_year_in),
        .i_days_to_add (i_days_to_add),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_day_out     (o_day_out),
        .o_month_out   (o_month_out),
        .o_year_out    (o_year_out)
    );

    always #10 i_clk = ~i_clk;

    // Days in month m of year y, Gregorian leap rule
    function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
        bit leap;
        leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        case (m)
            4, 6, 9, 11: return 30;
            2:           return leap ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    // Validate the date, then walk month by month until the day total fits
    function automatic t_date_result add_days_to_date(t_date_item it);
        t_date_result     r;
        int unsigned      d;
        int unsigned      m;
        int unsigned      y;
        longint unsigned  total;
        d = it.day;
        m = it.month;
        y = it.year;
        r.status = ST_OK;
        if (y < MIN_YEAR || m < 1 || m > MONTHS || d < 1 || d > days_in_month(m, y)) begin
            r.status = ST_BAD_DATE;
        end else if (y > MAX_YEAR) begin
            r.status = ST_OVERFLOW;
        end else begin
            total = d + (longint'(it.days) & ((64'd1 << ADD_WIDTH) - 1));
            while (total > days_in_month(m, y)) begin
                total -= days_in_month(m, y);
                m++;
                if (m > MONTHS) begin
                    m = 1;
                    y++;
                    if (y > MAX_YEAR) begin
                        r.status = ST_OVERFLOW;
                        break;
                    end
                end
            end
            d = int'(total);
        end
        // Saturate on year overflow
        if (r.status == ST_OVERFLOW) begin
            d = 31;
            m = MONTHS;
            y = MAX_YEAR;
        end
        r.day   = DAY_W'(d);
        r.month = MONTH_W'(m);
        r.year  = YEAR_W'(y);
        return r;
    endfunction

    task automatic queue_date(int unsigned d, int unsigned m, int unsigned y, int unsigned add);
        t_date_item it;
        it.day   = DAY_W'(d);
        it.month = MONTH_W'(m);
        it.year  = YEAR_W'(y);
        it.days  = DAYS_W'(add);
        date_items.push_back(it);
    endtask

    // Sender: record the prediction on each transfer, then offer the next item or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_dates.push_back(add_days_to_date(tx_item));
                sent_cnt <= sent_cnt + 1;
            end
            if (!i_valid || !o_stall) begin
                if (tx_gap != 0) begin
                    tx_gap  <= tx_gap - 1;
                    i_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    tx_gap  <= $urandom_range(0, 9);
                    i_valid <= 1'b0;
                end else if (date_items.size() != 0) begin
                    tx_item        = date_items.pop_front();
                    i_valid       <= 1'b1;
                    i_day_in      <= tx_item.day;
                    i_month_in    <= tx_item.month;
                    i_year_in     <= tx_item.year;
                    i_days_to_add <= tx_item.days;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold once, so the block backs up and stalls its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && sent_cnt >= HOLD_AT) begin
            hold_cnt  <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Receiver: check each transfer against the oldest prediction, then drive stall
    always @(posedge i_clk) begin
        t_date_result exp_r;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_gap  <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_dates.size() == 0) begin
                    $error("result with no pending date: status %0d %0d/%0d/%0d",
                           o_status, o_day_out, o_month_out, o_year_out);
                    err_cnt++;
                end else begin
                    exp_r = expected_dates.pop_front();
                    if (o_status !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, o_status);
                        err_cnt++;
                    end
                    if (o_day_out !== exp_r.day) begin
                        $error("day_out: expected %0d, got %0d", exp_r.day, o_day_out);
                        err_cnt++;
                    end
                    if (o_month_out !== exp_r.month) begin
                        $error("month_out: expected %0d, got %0d", exp_r.month, o_month_out);
                        err_cnt++;
                    end
                    if (o_year_out !== exp_r.year) begin
                        $error("year_out: expected %0d, got %0d", exp_r.year, o_year_out);
                        err_cnt++;
                    end
                end
            end
            if (hold_cnt > 1) begin
                i_stall <= 1'b1;
            end else if (rx_gap != 0) begin
                rx_gap  <= rx_gap - 1;
                i_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                rx_gap  <= $urandom_range(0, 9);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Abort on a hung run
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Build the stimulus, release reset, wait for the last result
    initial begin
        int unsigned d;
        int unsigned m;
        int unsigned y;
        int unsigned add;
        int unsigned sel;

        // Directed: field extremes, leap rules, invalid dates, overflow, zero days
        queue_date(1, 1, 1600, 0);
        queue_date(31, 12, 9999, 0);
        queue_date(31, 12, 9999, 1);
        queue_date(28, 2, 1900, 1);
        queue_date(28, 2, 2000, 1);
        queue_date(29, 2, 2004, 365);
        queue_date(29, 2, 1900, 0);
        queue_date(29, 2, 2000, 0);
        queue_date(31, 4, 2020, 3);
        queue_date(0, 5, 2020, 3);
        queue_date(15, 0, 2020, 3);
        queue_date(15, 13, 2020, 3);
        queue_date(31, 15, 2020, 3);
        queue_date(1, 1, 1599, 3);
        queue_date(0, 0, 0, 0);
        queue_date(31, 12, 2020, 1);
        queue_date(31, 1, 2023, 28);
        queue_date(1, 1, 1600, 65535);
        queue_date(31, 12, 9990, 65535);
        queue_date(15, 6, 12000, 0);
        queue_date(31, 12, 16383, 5);
        queue_date(10, 7, 9999, 200);
        queue_date(1, 3, 2024, 16'hAAAA);
        queue_date(1, 3, 2024, 16'h5555);

        // Random: mostly valid dates with short counts, some long, some noise
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sel = $urandom_range(0, 99);
            y   = $urandom_range(MIN_YEAR, MAX_YEAR);
            m   = $urandom_range(1, MONTHS);
            d   = $urandom_range(1, days_in_month(m, y));
            if (sel < 45) begin
                add = $urandom_range(0, 400);
            end else if (sel < 60) begin
                add = $urandom_range(0, 3000);
            end else if (sel < 66) begin
                add = $urandom_range(0, 65535);
            end else if (sel < 74) begin
                y   = $urandom_range(MAX_YEAR - 30, MAX_YEAR);
                d   = $urandom_range(1, days_in_month(m, y));
                add = $urandom_range(0, 16000);
            end else if (sel < 82) begin
                // Land on or just past the month end
                add = days_in_month(m, y) - d + $urandom_range(0, 1);
            end else begin
                d   = $urandom_range(0, 31);
                m   = $urandom_range(0, 15);
                y   = $urandom_range(0, 16383);
                add = $urandom_range(0, 65535);
            end
            queue_date(d, m, y, add);
        end
        item_total = date_items.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_cnt < item_total) @(posedge i_clk);
        while (expected_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/dvad_pkg.sv
design/date_validate_and_add_days.sv
test/testbench.sv
